/* sv/vco_clock_frequency_planner_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the VCO clock frequency planner
// Shared property wrappers; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VCO_CLOCK_FREQUENCY_PLANNER_CORE_ASSERT_SVH
`define VCO_CLOCK_FREQUENCY_PLANNER_CORE_ASSERT_SVH

// property checked every clock outside reset
`define VCFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked in the cycle after a trigger
`define VCFP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

/* sv/vcfp_pkg.sv */
// ----------------------------------------------------------------------------
// vcfp_pkg
// Types, constants and the setting-to-frequency function of the planner.
// ----------------------------------------------------------------------------
`default_nettype none

package vcfp_pkg;

  // field widths
  localparam int KHZ_W  = 20;
  localparam int FREQ_W = 19;
  localparam int MEM_W  = 18;
  localparam int WORD_W = 32;
  localparam int VDW_W  = 8;
  localparam int OD_W   = 3;
  localparam int DIV_W  = 4;
  localparam int ACT_W  = 2;
  localparam int CFG_IDX_W = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SET    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ROUND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DECODE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_MAX    = 2'd2;

  // register reset values
  localparam logic [KHZ_W-1:0] POLICY_MAX_RST = 20'd160000;
  localparam logic [KHZ_W-1:0] CPU_MIN_RST    = 20'd12000;
  localparam logic [KHZ_W-1:0] CPU_MAX_RST    = 20'd160000;

  // VCO window and rounding
  localparam int VCO_LO_KHZ = 10000;
  localparam int VCO_HI_KHZ = 320000;
  localparam logic [KHZ_W:0] ROUND_UP_KHZ = 21'd1999;
  localparam logic [VDW_W-1:0] VDW_MIN  = 8'd4;
  localparam logic [VDW_W-1:0] VDW_MAX  = 8'd152;
  localparam logic [VDW_W-1:0] VDW_BIAS = 8'd8;
  localparam logic [FREQ_W-1:0] FREQ_SAT = '1;

  // divide by 2000 = shift by 4, then multiply by reciprocal of 125
  localparam int VCO_W       = 24;
  localparam int STEP_SHIFT  = 4;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_125 = 21'd1073742;

  // dividers in ascending order with their od codes
  localparam int RANKS  = 8;
  localparam int RANK_W = 3;
  localparam logic [DIV_W-1:0] DIV_BY_RANK [RANKS] =
    '{4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10};
  localparam logic [OD_W-1:0] OD_BY_RANK [RANKS] =
    '{3'd1, 3'd3, 3'd4, 3'd7, 3'd5, 3'd2, 3'd6, 3'd0};

  typedef struct packed {
    logic [KHZ_W-1:0] policy_max;
    logic [KHZ_W-1:0] cpu_min;
    logic [KHZ_W-1:0] cpu_max;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KHZ_W-1:0]  khz;
    logic [WORD_W-1:0] word;
    logic [FREQ_W-1:0] old_freq;
    logic [MEM_W-1:0]  mem_freq;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] new_osc_word;
    logic              changed;
    logic [MEM_W-1:0]  mem_freq;
    logic [FREQ_W-1:0] new_freq;
    logic [FREQ_W-1:0] old_freq;
  } result_t;

  // 2000 * (vdw + 8) / div(od), floor; divisors 6, 7 and 9 split into exact
  // quotient plus a small reciprocal-corrected remainder term
  function automatic logic [FREQ_W-1:0] setting_khz(input logic [VDW_W-1:0] vdw,
                                                   input logic [OD_W-1:0]  od);
    logic [31:0] m;
    logic [31:0] f;
    m = 32'(vdw) + 32'd8;
    case (od)
      3'd0:    f = m * 32'd200;
      3'd1:    f = m * 32'd1000;
      3'd2:    f = m * 32'd250;
      3'd3:    f = m * 32'd500;
      3'd4:    f = m * 32'd400;
      3'd5:    f = m * 32'd285 + (((m * 32'd5) * 32'd4682) >> 15);
      3'd6:    f = m * 32'd222 + (((m * 32'd2) * 32'd3641) >> 15);
      default: f = m * 32'd333 + ((m * 32'd10923) >> 15);
    endcase
    return f[FREQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* sv/vcfp_front.sv */
// ----------------------------------------------------------------------------
// vcfp_front
// Accepts requests, prepares the frequency to plan and decodes the word.
// ----------------------------------------------------------------------------
`default_nettype none

module vcfp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vcfp_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [vcfp_pkg::ACT_W-1:0]  action,
  input  logic [vcfp_pkg::KHZ_W-1:0]  target_khz,
  input  logic                       relation_low,
  input  logic [vcfp_pkg::WORD_W-1:0] osc_word,
  input  logic                       q_full,
  output logic                       q_push,
  output vcfp_pkg::item_t            q_item
);
  import vcfp_pkg::*;

  logic           vld_r;
  logic           vld_nxt;
  item_t          item_r;
  item_t          item_nxt;
  logic           accept;
  logic [KHZ_W:0] sum;
  logic [KHZ_W-1:0] capped;
  logic [KHZ_W-1:0] raised;
  logic [KHZ_W-1:0] limited;
  logic [FREQ_W-1:0] mem_full;

  // a word may enter whenever the holding register is free or drains
  assign q_push   = vld_r && !q_full;
  assign in_ready = !vld_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_item   = item_r;

  // set target: round up, cap at policy
  assign sum    = {1'b0, target_khz} + (relation_low ? ROUND_UP_KHZ : '0);
  assign capped = (sum > {1'b0, cfg.policy_max}) ? cfg.policy_max : sum[KHZ_W-1:0];

  // round limit: raise to minimum, then lower to maximum
  assign raised  = (target_khz < cfg.cpu_min) ? cfg.cpu_min : target_khz;
  assign limited = (raised > cfg.cpu_max) ? cfg.cpu_max : raised;

  assign mem_full = setting_khz(osc_word[19:12], osc_word[22:20]);

  // classify
  always_comb begin
    item_nxt.action   = action;
    item_nxt.word     = osc_word;
    item_nxt.old_freq = setting_khz(osc_word[7:0], osc_word[10:8]);
    item_nxt.mem_freq = mem_full[FREQ_W-1:1];
    unique case (action)
      ACT_SET:   item_nxt.khz = capped;
      ACT_ROUND: item_nxt.khz = limited;
      default:   item_nxt.khz = target_khz;
    endcase
  end

  assign vld_nxt = accept ? 1'b1 : (q_push ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/vcfp_queue.sv */
// ----------------------------------------------------------------------------
// vcfp_queue
// Small register FIFO between the front and back of the planner.
// ----------------------------------------------------------------------------
`default_nettype none

module vcfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vcfp_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output vcfp_pkg::item_t item_out,
  output logic            empty
);
  import vcfp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign item_out = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

`include "vco_clock_frequency_planner_core_assert.svh"

  `VCFP_ASSERT(a_q_bound, cnt_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `VCFP_ASSERT(a_q_no_overrun, push |-> !full, "push into full queue")
  `VCFP_ASSERT_NEXT(a_q_fill, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count missed a push")

endmodule

`default_nettype wire

/* sv/vcfp_back.sv */
// ----------------------------------------------------------------------------
// vcfp_back
// Plans the divider and VCO word, converts back and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module vcfp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  vcfp_pkg::cfg_t    cfg,
  input  logic              q_empty,
  output logic              q_pop,
  input  vcfp_pkg::item_t   q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output vcfp_pkg::result_t out_res
);
  import vcfp_pkg::*;

  localparam int Y_W    = VCO_W - STEP_SHIFT;
  localparam int PROD_W = Y_W + RECIP_W;

  // stage valids: 0 select, 1 divide, 2 convert, 3 output
  logic [3:0]        vld_r;
  logic [3:0]        vld_nxt;
  logic              advance;

  logic [RANKS-1:0]  fits;
  logic [RANK_W-1:0] sel;
  logic [DIV_W-1:0]  div_sel;
  logic [VCO_W-1:0]  vco;

  item_t             s1_item_r;
  logic [OD_W-1:0]   s1_od_r;
  logic [Y_W-1:0]    s1_y_r;

  logic [PROD_W-1:0] prod;
  item_t             s2_item_r;
  logic [OD_W-1:0]   s2_od_r;
  logic [VDW_W-1:0]  s2_vdw_r;

  logic [VDW_W-1:0]  vdw_eff;
  item_t             s3_item_r;
  logic [OD_W-1:0]   s3_od_r;
  logic [VDW_W-1:0]  s3_vdw_r;
  logic [FREQ_W-1:0] s3_freq_r;

  logic [KHZ_W-1:0]  lim_lo;
  logic [KHZ_W-1:0]  lim;
  result_t           res_r;
  result_t           res_nxt;

  // whole pipeline moves when the output register can take a word
  assign advance   = !vld_r[3] || out_ready;
  assign q_pop     = advance && !q_empty;
  assign vld_nxt   = advance ? {vld_r[2:0], q_pop} : vld_r;
  assign out_valid = vld_r[3];
  assign out_res   = res_r;

  // VCO window per divider, as bounds on the frequency itself
  for (genvar r = 0; r < RANKS; r++) begin : g_win
    localparam int DIV_R = int'(DIV_BY_RANK[r]);
    localparam logic [KHZ_W-1:0] LO_R = KHZ_W'(VCO_LO_KHZ / DIV_R);
    localparam logic [KHZ_W-1:0] HI_R = KHZ_W'(VCO_HI_KHZ / DIV_R);
    assign fits[r] = (q_item.khz > LO_R) && (q_item.khz <= HI_R);
  end

  // first fitting divider, largest one when none fits
  always_comb begin
    sel = RANK_W'(RANKS - 1);
    for (int r = RANKS - 1; r >= 0; r--) begin
      if (fits[r]) begin
        sel = RANK_W'(r);
      end
    end
  end

  assign div_sel = DIV_BY_RANK[sel];
  assign vco     = VCO_W'(q_item.khz) * VCO_W'(div_sel);

  // divide by 125 through reciprocal; word kept modulo 256
  assign prod = PROD_W'(s1_y_r) * PROD_W'(RECIP_125);

  // round limit keeps the word inside its legal span
  always_comb begin
    vdw_eff = s2_vdw_r;
    if (s2_item_r.action == ACT_ROUND) begin
      if (s2_vdw_r < VDW_MIN) begin
        vdw_eff = VDW_MIN;
      end else if (s2_vdw_r > VDW_MAX) begin
        vdw_eff = VDW_MAX;
      end
    end
  end

  // clamp converted frequency to CPU limits
  assign lim_lo = ({1'b0, s3_freq_r} < cfg.cpu_min) ? cfg.cpu_min : {1'b0, s3_freq_r};
  assign lim    = (lim_lo > cfg.cpu_max) ? cfg.cpu_max : lim_lo;

  // result assembly
  always_comb begin
    res_nxt.old_freq     = s3_item_r.old_freq;
    res_nxt.new_osc_word = s3_item_r.word;
    res_nxt.new_freq     = '0;
    res_nxt.mem_freq     = '0;
    res_nxt.changed      = 1'b0;
    unique case (s3_item_r.action)
      ACT_SET: begin
        res_nxt.new_freq = s3_freq_r;
        if (s3_freq_r != s3_item_r.old_freq) begin
          res_nxt.changed      = 1'b1;
          res_nxt.new_osc_word = {s3_item_r.word[WORD_W-1:VDW_W+OD_W], s3_od_r, s3_vdw_r};
        end
      end
      ACT_ROUND: begin
        res_nxt.new_freq = (lim > {1'b0, FREQ_SAT}) ? FREQ_SAT : lim[FREQ_W-1:0];
      end
      ACT_DECODE: begin
        res_nxt.new_freq = s3_item_r.old_freq;
        res_nxt.mem_freq = s3_item_r.mem_freq;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item_r <= q_item;
      s1_od_r   <= OD_BY_RANK[sel];
      s1_y_r    <= vco[VCO_W-1:STEP_SHIFT];
      s2_item_r <= s1_item_r;
      s2_od_r   <= s1_od_r;
      s2_vdw_r  <= prod[RECIP_SHIFT +: VDW_W] - VDW_BIAS;
      s3_item_r <= s2_item_r;
      s3_od_r   <= s2_od_r;
      s3_vdw_r  <= vdw_eff;
      s3_freq_r <= setting_khz(vdw_eff, s2_od_r);
      res_r     <= res_nxt;
    end
  end

`include "vco_clock_frequency_planner_core_assert.svh"

  `VCFP_ASSERT_NEXT(a_bk_hold, !advance, $stable(vld_r), "back pipeline moved while stalled")
  `VCFP_ASSERT(a_bk_changed, vld_r[3] && res_r.changed |-> res_r.new_freq != res_r.old_freq, "changed flag without a new frequency")

endmodule

`default_nettype wire

/* sv/vco_clock_frequency_planner_core.sv */
// ----------------------------------------------------------------------------
// vco_clock_frequency_planner_core
// Converts between kHz and clock synthesizer oscillator settings.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream (action in in_tuser) and each gives one
//   result word on the out_ stream, in order. Limits are written through the
//   cfg_ port while no request is in flight; the user must keep to this, as
//   the block has no check of its own for it.
//   Throughput: one request per cycle, sustained while out_tready stays high.
//   Path to out_tvalid: the front holding register, the queue, then three
//   back stages (divider select, reciprocal multiply for the divide by 125,
//   setting to frequency conversion) ahead of the output register.
//   Reset: the pipeline and queue empty, the limits return to 160000,
//   12000 and 160000 kHz.
//   Stall: while a result waits and out_tready is low the back pipeline
//   holds; the queue then fills, the front register holds, and in_tready
//   drops. The result word stays stable until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vco_clock_frequency_planner_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: target_khz[19:0], relation_low[20], osc_word[52:21], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // in_tuser: action[1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: old_freq_khz[18:0], new_freq_khz[37:19], mclk_khz[55:38],
  //            changed[56], new_osc_word[88:57], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  input  logic        cfg_we,
  input  logic [vcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vcfp_pkg::KHZ_W-1:0]     cfg_wdata
);
  import vcfp_pkg::*;

  cfg_t    cfg_r;
  item_t   fr_item;
  item_t   q_item;
  result_t res;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy_max <= POLICY_MAX_RST;
      cfg_r.cpu_min    <= CPU_MIN_RST;
      cfg_r.cpu_max    <= CPU_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY_MAX: cfg_r.policy_max <= cfg_wdata;
        CFG_CPU_MIN:    cfg_r.cpu_min    <= cfg_wdata;
        CFG_CPU_MAX:    cfg_r.cpu_max    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  vcfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .action       (in_tuser),
    .target_khz   (in_tdata[19:0]),
    .relation_low (in_tdata[20]),
    .osc_word     (in_tdata[52:21]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (fr_item)
  );

  vcfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (fr_item),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (q_item),
    .empty    (q_empty)
  );

  vcfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'b0, res.new_osc_word, res.changed, res.mem_freq,
                      res.new_freq, res.old_freq};

endmodule

`default_nettype wire

/* tb/sv/vco_clock_frequency_planner_core_tb.sv */
// ----------------------------------------------------------------------------
// vco_clock_frequency_planner_core_tb
// Self-checking bench for the frequency planner: drives set-target, round-limit,
// decode and unused-action requests under several limit settings and idle
// patterns, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module vco_clock_frequency_planner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned STEP_KHZ = 2000;
  localparam int unsigned VCO_FLOOR_KHZ = 10000;
  localparam int unsigned VCO_CEIL_KHZ = 320000;
  localparam int unsigned ROUND_UP_KHZ = 1999;
  localparam int unsigned FREQ_SAT_KHZ = 524287;
  localparam int unsigned KHZ_TOP = 1048575;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_WORDS = 425;

  // oscillator setting: divider index over VCO word
  typedef struct packed {
    logic [2:0] od;
    logic [7:0] vdw;
  } osc_setting_t;

  // result word, fields listed from the top bit down
  typedef struct packed {
    logic [31:0] nword;
    logic        changed;
    logic [17:0] mem;
    logic [18:0] newf;
    logic [18:0] oldf;
  } planner_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // in_tdata: target_khz[19:0], relation_low[20], osc_word[52:21], zero pad
  logic [55:0] in_tdata = '0;
  // in_tuser: action[1:0]
  logic [1:0]  in_tuser = vcfp_pkg::ACT_SET;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata: old_freq_khz[18:0], new_freq_khz[37:19], mclk_khz[55:38],
  //            changed[56], new_osc_word[88:57], zero pad
  logic [95:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [vcfp_pkg::CFG_IDX_W-1:0] cfg_index = vcfp_pkg::CFG_POLICY_MAX;
  logic [vcfp_pkg::KHZ_W-1:0]     cfg_wdata = '0;

  // bench copy of the limit registers
  logic [19:0] limit_policy_khz = 20'd160000;
  logic [19:0] limit_min_khz = 20'd12000;
  logic [19:0] limit_max_khz = 20'd160000;

  planner_word_t expected_words[$];
  planner_word_t want;
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  vco_clock_frequency_planner_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned divisor_of(input logic [2:0] od);
    case (od)
      3'd0: return 10;
      3'd1: return 2;
      3'd2: return 8;
      3'd3: return 4;
      3'd4: return 5;
      3'd5: return 7;
      3'd6: return 9;
      default: return 6;
    endcase
  endfunction

  // divider index by ascending divisor
  function automatic logic [2:0] od_at_rank(input int rank);
    case (rank)
      0: return 3'd1;
      1: return 3'd3;
      2: return 3'd4;
      3: return 3'd7;
      4: return 3'd5;
      5: return 3'd2;
      6: return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

  function automatic int unsigned vco_khz(input logic [7:0] vdw, input logic [2:0] od,
                                          input int unsigned factor);
    int unsigned vco;
    vco = STEP_KHZ * (32'(vdw) + 8);
    return vco / divisor_of(od) / factor;
  endfunction

  // first divider that puts the VCO in its window; largest divider otherwise
  function automatic osc_setting_t plan_setting(input int unsigned khz);
    int unsigned vco;
    int rank;
    bit hit;
    osc_setting_t s;
    vco = 0;
    rank = 0;
    hit = 1'b0;
    while (!hit && rank < 8) begin
      vco = khz * divisor_of(od_at_rank(rank));
      if (vco > VCO_FLOOR_KHZ && vco <= VCO_CEIL_KHZ) hit = 1'b1;
      else rank++;
    end
    if (!hit) rank = 7;
    s.od = od_at_rank(rank);
    s.vdw = 8'(vco / STEP_KHZ - 8);  // wraps when out of byte range
    return s;
  endfunction

  function automatic int unsigned clamp_limit(input int unsigned v);
    if (v < limit_min_khz) v = limit_min_khz;
    if (v > limit_max_khz) v = limit_max_khz;
    return v;
  endfunction

  function automatic planner_word_t predict_word(input logic [1:0] act, input logic [19:0] khz,
                                                 input logic low, input logic [31:0] word);
    int unsigned oldf;
    int unsigned newf;
    int unsigned memf;
    int unsigned t;
    osc_setting_t s;
    planner_word_t r;
    oldf = vco_khz(word[7:0], word[10:8], 1);
    newf = 0;
    memf = 0;
    r.changed = 1'b0;
    r.nword = word;
    case (act)
      vcfp_pkg::ACT_SET: begin
        t = khz;
        if (low) t = t + ROUND_UP_KHZ;
        if (t > limit_policy_khz) t = limit_policy_khz;
        s = plan_setting(t);
        newf = vco_khz(s.vdw, s.od, 1);
        if (newf != oldf) begin
          r.changed = 1'b1;
          r.nword = {word[31:11], s.od, s.vdw};
        end
      end
      vcfp_pkg::ACT_ROUND: begin
        s = plan_setting(clamp_limit(khz));
        if (s.vdw < 8'd4) s.vdw = 8'd4;
        if (s.vdw > 8'd152) s.vdw = 8'd152;
        newf = clamp_limit(vco_khz(s.vdw, s.od, 1));
        if (newf > FREQ_SAT_KHZ) newf = FREQ_SAT_KHZ;
      end
      vcfp_pkg::ACT_DECODE: begin
        newf = oldf;
        memf = vco_khz(word[19:12], word[22:20], 2);
      end
      default: ;
    endcase
    r.oldf = 19'(oldf);
    r.newf = 19'(newf);
    r.mem = 18'(memf);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [95:0] got,
                                 input logic [95:0] exp_val);
    $display("[%0t] %s: got %0h, want %0h", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none pending", out_tdata, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_tdata[18:0] !== want.oldf)
          report_mismatch("old_freq_khz", out_tdata[18:0], want.oldf);
        if (out_tdata[37:19] !== want.newf)
          report_mismatch("new_freq_khz", out_tdata[37:19], want.newf);
        if (out_tdata[55:38] !== want.mem)
          report_mismatch("mclk_khz", out_tdata[55:38], want.mem);
        if (out_tdata[56] !== want.changed)
          report_mismatch("changed", out_tdata[56], want.changed);
        if (out_tdata[88:57] !== want.nword)
          report_mismatch("new_osc_word", out_tdata[88:57], want.nword);
        if (out_tdata[95:89] !== 7'd0)
          report_mismatch("tdata pad", out_tdata[95:89], '0);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) out_tready = ($urandom_range(99) >= stall_pct);

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // entered and left at a falling edge; valid stays up for back-to-back words
  task automatic send_word(input logic [1:0] act, input logic [19:0] khz, input logic low,
                           input logic [31:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = {3'b000, word, low, khz};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_words.push_back(predict_word(act, khz, low, word));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // limits change only with nothing in flight
  task automatic write_reg(input logic [vcfp_pkg::CFG_IDX_W-1:0] idx, input logic [19:0] value);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      vcfp_pkg::CFG_POLICY_MAX: limit_policy_khz = value;
      vcfp_pkg::CFG_CPU_MIN:    limit_min_khz = value;
      vcfp_pkg::CFG_CPU_MAX:    limit_max_khz = value;
      default: ;
    endcase
  endtask

  // mostly the range where divider choice matters, plus window edges and noise
  function automatic logic [19:0] random_khz();
    int unsigned d;
    d = $urandom_range(10, 2);
    case ($urandom_range(9))
      0, 1, 2, 3: return 20'($urandom_range(40000, 1000));
      4, 5, 6:    return 20'($urandom_range(200000, 0));
      7: return 20'(($urandom_range(1, 0) ? VCO_CEIL_KHZ : VCO_FLOOR_KHZ) / d
                    + $urandom_range(2, 0) - 1);
      default: return 20'($urandom());
    endcase
  endfunction

  task automatic send_random_word();
    logic [1:0] act;
    logic [19:0] khz;
    logic low;
    logic [31:0] word;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) act = vcfp_pkg::ACT_SET;
    else if (pick < 70) act = vcfp_pkg::ACT_ROUND;
    else if (pick < 90) act = vcfp_pkg::ACT_DECODE;
    else act = ACT_UNUSED;
    khz = random_khz();
    low = 1'($urandom_range(1, 0));
    word = $urandom();
    // ask for the current frequency now and then, so nothing changes
    if (act == vcfp_pkg::ACT_SET && $urandom_range(3) == 0) begin
      low = 1'b0;
      khz = 20'(vco_khz(word[7:0], word[10:8], 1));
    end
    send_word(act, khz, low, word);
  endtask

  // ---------------------------------------------------------------- tests
  // field extremes and each action at reset limits
  task automatic test_reset_limits();
    send_word(vcfp_pkg::ACT_SET, 20'd0, 1'b0, 32'h0000_0000);       // no divider fits
    send_word(vcfp_pkg::ACT_SET, 20'hfffff, 1'b1, 32'hffff_ffff);   // capped by policy
    send_word(vcfp_pkg::ACT_SET, 20'd5000, 1'b0, 32'h0000_0000);    // VCO floor is exclusive
    send_word(vcfp_pkg::ACT_SET, 20'd160000, 1'b0, 32'h1234_5678);  // VCO ceiling inclusive
    send_word(vcfp_pkg::ACT_SET, 20'd158001, 1'b1, 32'h8765_4321);
    send_word(vcfp_pkg::ACT_SET, 20'd74000, 1'b0, 32'hdead_b942);   // already there
    send_word(vcfp_pkg::ACT_ROUND, 20'd0, 1'b0, 32'h0000_0000);     // raised to minimum
    send_word(vcfp_pkg::ACT_ROUND, 20'hfffff, 1'b1, 32'hffff_ffff); // lowered to maximum
    send_word(vcfp_pkg::ACT_ROUND, 20'd12345, 1'b0, 32'h0f0f_0f0f);
    send_word(vcfp_pkg::ACT_DECODE, 20'd0, 1'b0, 32'hffff_ffff);
    send_word(vcfp_pkg::ACT_DECODE, 20'hfffff, 1'b1, 32'h0000_0000);
    send_word(vcfp_pkg::ACT_DECODE, 20'h5a5a5, 1'b0, 32'h0055_5aa5);
    send_word(ACT_UNUSED, 20'hfffff, 1'b1, 32'ha5a5_a5a5);
  endtask

  // limit registers at their extremes, including a crossed min/max
  task automatic test_limit_extremes();
    write_reg(vcfp_pkg::CFG_POLICY_MAX, 20'hfffff);
    write_reg(vcfp_pkg::CFG_CPU_MIN, 20'd0);
    write_reg(vcfp_pkg::CFG_CPU_MAX, 20'hfffff);
    send_word(vcfp_pkg::ACT_SET, 20'hfffff, 1'b1, 32'h0000_07ff);
    send_word(vcfp_pkg::ACT_ROUND, 20'd0, 1'b0, 32'hffff_f800);     // word wraps, then clamped
    send_word(vcfp_pkg::ACT_ROUND, 20'hfffff, 1'b0, 32'h0000_0000);
    write_reg(vcfp_pkg::CFG_CPU_MIN, 20'hfffff);
    send_word(vcfp_pkg::ACT_ROUND, 20'd0, 1'b1, 32'h0000_0104);     // saturates the field
    write_reg(vcfp_pkg::CFG_POLICY_MAX, 20'd0);
    write_reg(vcfp_pkg::CFG_CPU_MIN, 20'd0);
    write_reg(vcfp_pkg::CFG_CPU_MAX, 20'd0);
    send_word(vcfp_pkg::ACT_SET, 20'd5000, 1'b1, 32'h0000_0142);
    send_word(vcfp_pkg::ACT_ROUND, 20'd50000, 1'b0, 32'h0000_0142);
    write_reg(vcfp_pkg::CFG_CPU_MIN, 20'd90000);                    // min above max
    send_word(vcfp_pkg::ACT_ROUND, 20'd30000, 1'b0, 32'h0000_0000);
  endtask

  task automatic set_limits(input logic [19:0] policy, input logic [19:0] lo,
                            input logic [19:0] hi);
    write_reg(vcfp_pkg::CFG_POLICY_MAX, policy);
    write_reg(vcfp_pkg::CFG_CPU_MIN, lo);
    write_reg(vcfp_pkg::CFG_CPU_MAX, hi);
  endtask

  // random traffic under one idle pattern; drains once halfway through
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int words);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int i = 0; i < words; i++) begin
      if (i == words / 2) wait_drained();
      send_random_word();
    end
    wait_drained();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_reset_limits();
    test_limit_extremes();

    set_limits(20'd160000, 20'd12000, 20'd160000);
    test_random_traffic(0, 0, PHASE_WORDS);
    set_limits(random_khz(), 20'($urandom_range(50000, 0)), 20'($urandom_range(300000, 50000)));
    test_random_traffic(71, 0, PHASE_WORDS);
    set_limits(20'(KHZ_TOP), 20'd0, 20'(KHZ_TOP));
    test_random_traffic(0, 71, PHASE_WORDS);
    set_limits(random_khz(), random_khz(), random_khz());
    test_random_traffic(22, 22, PHASE_WORDS);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
